// File: rtl/tvelnu_pkg.sv
// shared types and constants for the visible escape and line numbering unit
package tvelnu_pkg;

    localparam int NUM_DIGITS = 6;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int BODY_MAX   = 4;
    localparam int MAX_OUT    = NUM_DIGITS + 1 + BODY_MAX;
    localparam int CNT_W      = $clog2(MAX_OUT + 1);
    localparam int BLEN_W     = $clog2(BODY_MAX + 1);
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_NUMBER_ALL      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUMBER_NONBLANK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SQUEEZE_BLANK   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHOW_ENDS       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHOW_TABS       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SHOW_NONPRINT   = 3'd5;

    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_DOLLAR  = 8'd36;
    localparam logic [7:0] CH_MINUS   = 8'd45;
    localparam logic [7:0] CH_ZERO    = 8'd48;
    localparam logic [7:0] CH_QUEST   = 8'd63;
    localparam logic [7:0] CH_UPPER_I = 8'd73;
    localparam logic [7:0] CH_UPPER_M = 8'd77;
    localparam logic [7:0] CH_CARET   = 8'd94;
    localparam logic [7:0] CH_DEL     = 8'd127;

    typedef struct packed {
        logic number_all;
        logic number_nonblank;
        logic squeeze_blank;
        logic show_ends;
        logic show_tabs;
        logic show_nonprint;
    } cfg_t;

    typedef logic [MAX_OUT-1:0][7:0] byte_seq_t;

    typedef struct packed {
        byte_seq_t        bytes;
        logic [CNT_W-1:0] count;
    } job_t;

endpackage

// File: rtl/tvelnu_cfg_regs.sv
// configuration register file
module tvelnu_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tvelnu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic                           cfg_data,
    output tvelnu_pkg::cfg_t               cfg
);

    tvelnu_pkg::cfg_t cfg_reg;
    tvelnu_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                tvelnu_pkg::REG_NUMBER_ALL:      cfg_next.number_all      = cfg_data;
                tvelnu_pkg::REG_NUMBER_NONBLANK: cfg_next.number_nonblank = cfg_data;
                tvelnu_pkg::REG_SQUEEZE_BLANK:   cfg_next.squeeze_blank   = cfg_data;
                tvelnu_pkg::REG_SHOW_ENDS:       cfg_next.show_ends       = cfg_data;
                tvelnu_pkg::REG_SHOW_TABS:       cfg_next.show_tabs       = cfg_data;
                tvelnu_pkg::REG_SHOW_NONPRINT:   cfg_next.show_nonprint   = cfg_data;
                default:                         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

endmodule

// File: rtl/tvelnu_line_state.sv
// line tracking state, escape decode and output sequence assembly
module tvelnu_line_state (
    input  logic               clk,
    input  logic               rst_n,
    input  tvelnu_pkg::cfg_t   cfg,
    input  logic [7:0]         data_byte,
    input  logic               first_of_file,
    input  logic               take,
    output logic               drop,
    output tvelnu_pkg::job_t   job
);

    localparam int ND = tvelnu_pkg::NUM_DIGITS;
    localparam logic [tvelnu_pkg::BCD_W-1:0] BCD_ONE = tvelnu_pkg::BCD_W'(1);

    logic [tvelnu_pkg::BCD_W-1:0] bcd_reg, bcd_next;
    logic                         line_start_reg, line_start_next;
    logic                         prev_blank_reg, prev_blank_next;

    logic [tvelnu_pkg::BCD_W-1:0] bcd_eff, bcd_inc;
    logic                         line_start, blank, numbered;
    logic [tvelnu_pkg::BODY_MAX-1:0][7:0] body;
    logic [tvelnu_pkg::BLEN_W-1:0] body_len;
    logic [ND-1:0][7:0]           digit_ch;

    assign bcd_eff    = first_of_file ? BCD_ONE : bcd_reg;
    assign line_start = first_of_file | line_start_reg;
    assign blank      = (data_byte == tvelnu_pkg::CH_NEWLINE);
    assign drop       = line_start & cfg.squeeze_blank & blank & prev_blank_reg;
    assign numbered   = line_start & (cfg.number_nonblank ? !blank : cfg.number_all);

    // saturating bcd increment
    always_comb
    begin
        logic       all_nines;
        logic       carry;
        logic [3:0] d;
        all_nines = 1'b1;
        carry     = 1'b1;
        bcd_inc   = bcd_eff;
        for (int i = 0; i < ND; i++)
        begin
            if (bcd_eff[4*i +: 4] != 4'd9)
                all_nines = 1'b0;
        end
        for (int i = 0; i < ND; i++)
        begin
            d = bcd_eff[4*i +: 4];
            if (carry)
            begin
                if (d < 4'd9)
                begin
                    bcd_inc[4*i +: 4] = d + 4'd1;
                    carry = 1'b0;
                end
                else
                    bcd_inc[4*i +: 4] = 4'd0;
            end
        end
        if (all_nines)
            bcd_inc = bcd_eff;
    end

    // right aligned number text, leading zeros become spaces
    always_comb
    begin
        logic       leading;
        logic [3:0] d;
        leading = 1'b1;
        for (int i = ND - 1; i >= 0; i--)
        begin
            d = bcd_eff[4*i +: 4];
            if (d != 4'd0 || i == 0)
                leading = 1'b0;
            if (leading)
                digit_ch[i] = tvelnu_pkg::CH_SPACE;
            else
                digit_ch[i] = tvelnu_pkg::CH_ZERO + {4'd0, (d > 4'd9) ? 4'd9 : d};
        end
    end

    // escaped form of the byte itself
    always_comb
    begin
        body     = '0;
        body_len = tvelnu_pkg::BLEN_W'(1);
        body[0]  = data_byte;
        if (blank && cfg.show_ends)
        begin
            body[0]  = tvelnu_pkg::CH_DOLLAR;
            body[1]  = tvelnu_pkg::CH_NEWLINE;
            body_len = tvelnu_pkg::BLEN_W'(2);
        end
        else if (data_byte == tvelnu_pkg::CH_TAB && cfg.show_tabs)
        begin
            body[0]  = tvelnu_pkg::CH_CARET;
            body[1]  = tvelnu_pkg::CH_UPPER_I;
            body_len = tvelnu_pkg::BLEN_W'(2);
        end
        else if (cfg.show_nonprint && data_byte != tvelnu_pkg::CH_TAB && !blank)
        begin
            if (data_byte <= 8'd31)
            begin
                body[0]  = tvelnu_pkg::CH_CARET;
                body[1]  = data_byte + 8'd64;
                body_len = tvelnu_pkg::BLEN_W'(2);
            end
            else if (data_byte == tvelnu_pkg::CH_DEL)
            begin
                body[0]  = tvelnu_pkg::CH_CARET;
                body[1]  = tvelnu_pkg::CH_QUEST;
                body_len = tvelnu_pkg::BLEN_W'(2);
            end
            else if (data_byte >= 8'd128 && data_byte <= 8'd159)
            begin
                body[0]  = tvelnu_pkg::CH_UPPER_M;
                body[1]  = tvelnu_pkg::CH_MINUS;
                body[2]  = tvelnu_pkg::CH_CARET;
                body[3]  = data_byte - 8'd64;
                body_len = tvelnu_pkg::BLEN_W'(4);
            end
            else if (data_byte >= 8'd160 && data_byte <= 8'd254)
            begin
                body[0]  = tvelnu_pkg::CH_UPPER_M;
                body[1]  = tvelnu_pkg::CH_MINUS;
                body[2]  = data_byte - 8'd128;
                body_len = tvelnu_pkg::BLEN_W'(3);
            end
            else if (data_byte == 8'd255)
            begin
                body[0]  = tvelnu_pkg::CH_UPPER_M;
                body[1]  = tvelnu_pkg::CH_MINUS;
                body[2]  = tvelnu_pkg::CH_CARET;
                body[3]  = tvelnu_pkg::CH_QUEST;
                body_len = tvelnu_pkg::BLEN_W'(4);
            end
        end
    end

    // sequence in emission order, entry 0 goes out first
    always_comb
    begin
        job = '0;
        if (numbered)
        begin
            for (int k = 0; k < ND; k++)
                job.bytes[k] = digit_ch[ND-1-k];
            job.bytes[ND] = tvelnu_pkg::CH_TAB;
            for (int j = 0; j < tvelnu_pkg::BODY_MAX; j++)
                job.bytes[ND+1+j] = body[j];
            job.count = tvelnu_pkg::CNT_W'(ND + 1) + tvelnu_pkg::CNT_W'(body_len);
        end
        else
        begin
            for (int j = 0; j < tvelnu_pkg::BODY_MAX; j++)
                job.bytes[j] = body[j];
            job.count = tvelnu_pkg::CNT_W'(body_len);
        end
    end

    always_comb
    begin
        bcd_next        = bcd_reg;
        line_start_next = line_start_reg;
        prev_blank_next = prev_blank_reg;
        if (take)
        begin
            if (drop)
            begin
                bcd_next        = bcd_eff;
                line_start_next = 1'b1;
            end
            else
            begin
                bcd_next        = numbered ? bcd_inc : bcd_eff;
                line_start_next = blank;
                if (line_start)
                    prev_blank_next = blank;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcd_reg        <= BCD_ONE;
            line_start_reg <= 1'b1;
            prev_blank_reg <= 1'b0;
        end
        else
        begin
            bcd_reg        <= bcd_next;
            line_start_reg <= line_start_next;
            prev_blank_reg <= prev_blank_next;
        end
    end

endmodule

// File: rtl/tvelnu_emitter.sv
// output sequence shifter and output register
module tvelnu_emitter (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  tvelnu_pkg::job_t job,
    output logic             load_ready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,
    output logic             m_tlast
);

    localparam int MO = tvelnu_pkg::MAX_OUT;

    tvelnu_pkg::byte_seq_t        seq_reg, seq_next;
    logic [tvelnu_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                         out_valid_reg, out_valid_next;
    logic [7:0]                   out_data_reg;
    logic                         out_last_reg;
    logic                         out_adv, emit, last_byte;

    assign out_adv    = !out_valid_reg || m_tready;
    assign emit       = (cnt_reg != '0) && out_adv;
    assign last_byte  = (cnt_reg == tvelnu_pkg::CNT_W'(1));
    assign load_ready = (cnt_reg == '0) || (last_byte && out_adv);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    always_comb
    begin
        seq_next       = seq_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_adv ? emit : out_valid_reg;
        if (load)
        begin
            seq_next = job.bytes;
            cnt_next = job.count;
        end
        else if (emit)
        begin
            for (int k = 0; k < MO - 1; k++)
                seq_next[k] = seq_reg[k+1];
            seq_next[MO-1] = '0;
            cnt_next = cnt_reg - tvelnu_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seq_reg <= seq_next;
        if (emit)
        begin
            out_data_reg <= seq_reg[0];
            out_last_reg <= last_byte;
        end
    end

endmodule

// File: rtl/text_visible_escape_line_numberer_unit.sv
// top level of the visible escape and line numbering unit
//
// Formats a text byte stream: optional six-place line number and tab at the
// start of each line (all lines or non-blank lines only), squeezing of repeated
// blank lines, '$' before newlines, ^I for tabs, and caret / M- notation for
// control and high bytes. s_tuser marks the first byte of a file and restarts
// numbering at 1. Each input byte yields 1 to 11 output bytes (none for a
// squeezed blank line); m_tlast marks the last byte produced by one input byte.
// The output shifter sends one byte per cycle while m_tready is high, and a
// new input byte is taken only as it sends the last byte of the one before:
// plain text flows at one byte per cycle, a numbered line start adds 7 bytes,
// escapes 1 to 3. A squeezed line is consumed without using the shifter. Data
// goes through the input register, shifter and output register. Configuration
// writes are always ready and should only be made while the unit is idle.
module text_visible_escape_line_numberer_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // data_byte
    input  logic                             s_tuser,   // first_of_file
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,   // out_byte
    output logic                             m_tlast,   // last_of_run
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tvelnu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic                             cfg_data
);

    tvelnu_pkg::cfg_t cfg;
    tvelnu_pkg::job_t job;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_first_reg;
    logic       take, drop, load_ready;

    // a squeezed line is consumed without occupying the shifter
    assign take     = in_valid_reg && (drop || load_ready);
    assign s_tready = !in_valid_reg || take;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tready)
            in_valid_next = s_tvalid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg  <= s_tdata;
            in_first_reg <= s_tuser;
        end
    end

    tvelnu_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tvelnu_line_state u_line_state (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .data_byte     (in_byte_reg),
        .first_of_file (in_first_reg),
        .take          (take),
        .drop          (drop),
        .job           (job)
    );

    tvelnu_emitter u_emitter (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (take && !drop),
        .job        (job),
        .load_ready (load_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule
